@@ src/dnsr_pkg.sv @@
// types, constants and the answer record table of the dns a-record responder
`timescale 1ns / 1ps
`default_nettype none

package dnsr_pkg;

   // fixed header offsets of the query
   localparam int OFS_FLAGS_HI  = 2;
   localparam int OFS_FLAGS_LO  = 3;
   localparam int OFS_QDCOUNT_H = 4;
   localparam int OFS_QDCOUNT_L = 5;
   localparam int OFS_COUNTS    = 6;
   localparam int OFS_ANCOUNT_L = 7;
   localparam int HEADER_BYTES  = 12;
   localparam int QTAIL_BYTES   = 5;
   localparam int ANSWER_BYTES  = 16;
   localparam int STOP_WALK_GAP = 1024;

   localparam logic [7:0] FLAGS_REPLY    = 8'h84;
   localparam logic [7:0] QR_BIT         = 8'h80;
   localparam logic [7:0] LABEL_PTR_MASK = 8'hC0;
   localparam logic [15:0] QTYPE_A       = 16'd1;
   localparam logic [15:0] ONE_QUESTION  = 16'd1;

   // short queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   // back-end step codes: byte, answer bytes, verdict
   localparam logic [4:0] STEP_BYTE    = 5'd0;
   localparam logic [4:0] STEP_ANS_1ST = 5'd1;
   localparam logic [4:0] STEP_ANS_END = 5'd16;
   localparam logic [4:0] STEP_VERDICT = 5'd17;

   typedef struct packed {
      logic [7:0] data;
      logic       fwd;
      logic       last;
      logic       ok;
   } dnsr_cmd_type;

   // answer record: pointer to offset 12, type a, class in, ttl 30, rdlength 4, address
   function automatic logic [7:0] answer_byte(input logic [3:0] idx, input logic [31:0] addr);
      logic [7:0] res;
      unique case (idx) inside
         4'd0:                      res = 8'hC0;
         4'd1:                      res = 8'h0C;
         4'd3, 4'd5:                res = 8'h01;
         4'd9:                      res = 8'd30;
         4'd11:                     res = 8'h04;
         4'd12:                     res = addr[31:24];
         4'd13:                     res = addr[23:16];
         4'd14:                     res = addr[15:8];
         4'd15:                     res = addr[7:0];
         4'd2, 4'd4, [4'd6:4'd8], 4'd10: res = 8'h00;
         default:                   res = 8'h00;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

@@ src/dnsr_front.sv @@
// front end: accepts query bytes, rewrites the header, walks labels, decides the verdict
`timescale 1ns / 1ps
`default_nettype none

module dnsr_front import dnsr_pkg::*; #(
   parameter int BUF_BYTES = 512
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last_byte,
   output logic              push_valid,
   input  wire logic         push_ready,
   output dnsr_cmd_type      push_cmd
);

   localparam int PW = $clog2(BUF_BYTES + 1);
   localparam int NW = $clog2(BUF_BYTES + STOP_WALK_GAP + 1);
   localparam logic [NW-1:0] BUF_N    = NW'(BUF_BYTES);
   localparam logic [NW-1:0] STOP_N   = NW'(BUF_BYTES + STOP_WALK_GAP);
   localparam logic [NW-1:0] LABEL_N  = NW'(HEADER_BYTES);

   logic [PW-1:0] byte_position_ff, byte_position_in;
   logic [NW-1:0] next_label_at_ff, next_label_at_in;
   logic          name_done_ff, name_done_in;
   logic [NW-1:0] question_end_ff, question_end_in;
   logic [7:0]    count_high_byte_ff, count_high_byte_in;
   logic [15:0]   type_value_ff, type_value_in;
   logic          rejected_ff, rejected_in;

   logic [NW-1:0] pos;
   logic [NW-1:0] n_after;
   logic          counted;
   logic          fwd;
   logic          ok;
   logic [7:0]    ob;
   logic          take;

   always_comb begin
      pos                = NW'(byte_position_ff);
      counted            = pos < BUF_N;
      byte_position_in   = byte_position_ff;
      next_label_at_in   = next_label_at_ff;
      name_done_in       = name_done_ff;
      question_end_in    = question_end_ff;
      count_high_byte_in = count_high_byte_ff;
      type_value_in      = type_value_ff;
      rejected_in        = rejected_ff;
      ob                 = req_data_byte;
      fwd                = 1'b0;

      if (counted) begin
         fwd = !name_done_ff || (pos < question_end_ff);
         if (pos == NW'(OFS_FLAGS_HI)) begin
            if ((req_data_byte & QR_BIT) != 8'h00) begin
               rejected_in = 1'b1;
            end
            ob = FLAGS_REPLY;
         end else if (pos == NW'(OFS_FLAGS_LO)) begin
            ob = 8'h00;
         end else if (pos == NW'(OFS_QDCOUNT_H)) begin
            count_high_byte_in = req_data_byte;
         end else if (pos == NW'(OFS_QDCOUNT_L)) begin
            if ({count_high_byte_ff, req_data_byte} != ONE_QUESTION) begin
               rejected_in = 1'b1;
            end
         end
         if (pos >= NW'(OFS_COUNTS) && pos < LABEL_N) begin
            ob = (pos == NW'(OFS_ANCOUNT_L)) ? 8'h01 : 8'h00;
         end

         if (!name_done_ff && pos == next_label_at_ff) begin
            if (req_data_byte == 8'h00) begin
               name_done_in    = 1'b1;
               question_end_in = pos + NW'(QTAIL_BYTES);
            end else if ((req_data_byte & LABEL_PTR_MASK) == LABEL_PTR_MASK) begin
               rejected_in      = 1'b1;
               next_label_at_in = STOP_N;
            end else begin
               next_label_at_in = pos + NW'(req_data_byte) + NW'(1);
            end
         end else if (name_done_ff) begin
            if (pos + NW'(4) == question_end_ff) begin
               type_value_in = {req_data_byte, type_value_ff[7:0]};
            end else if (pos + NW'(3) == question_end_ff) begin
               type_value_in = {type_value_ff[15:8], req_data_byte};
            end
         end
         byte_position_in = byte_position_ff + PW'(1);
      end

      n_after = NW'(byte_position_in);
      ok = (n_after >= LABEL_N) && !rejected_in && name_done_in &&
           (question_end_in <= n_after) && (type_value_in == QTYPE_A) &&
           (question_end_in + NW'(ANSWER_BYTES) <= BUF_N);
   end

   assign req_ready     = push_ready;
   assign take          = req_valid && push_ready;
   assign push_valid    = req_valid && (fwd || req_last_byte);
   assign push_cmd.data = ob;
   assign push_cmd.fwd  = fwd;
   assign push_cmd.last = req_last_byte;
   assign push_cmd.ok   = ok;

   always_ff @(posedge clock) begin
      if (reset || (take && req_last_byte)) begin
         byte_position_ff   <= '0;
         next_label_at_ff   <= LABEL_N;
         name_done_ff       <= 1'b0;
         question_end_ff    <= '0;
         count_high_byte_ff <= '0;
         type_value_ff      <= '0;
         rejected_ff        <= 1'b0;
      end else if (take) begin
         byte_position_ff   <= byte_position_in;
         next_label_at_ff   <= next_label_at_in;
         name_done_ff       <= name_done_in;
         question_end_ff    <= question_end_in;
         count_high_byte_ff <= count_high_byte_in;
         type_value_ff      <= type_value_in;
         rejected_ff        <= rejected_in;
      end
   end

endmodule

`default_nettype wire

@@ src/dnsr_queue.sv @@
// short command queue between front end and back end
`timescale 1ns / 1ps
`default_nettype none

module dnsr_queue import dnsr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_valid,
   output logic              push_ready,
   input  wire dnsr_cmd_type push_cmd,
   output logic              pop_valid,
   input  wire logic         pop_ready,
   output dnsr_cmd_type      pop_cmd
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   dnsr_cmd_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]             count_ff;
   logic                      do_push, do_pop;

   assign push_ready = count_ff != CW'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_AW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_AW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

`default_nettype wire

@@ src/dnsr_back.sv @@
// back end: emits forwarded bytes, the appended answer and the verdict beat
`timescale 1ns / 1ps
`default_nettype none

module dnsr_back import dnsr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [31:0]  answer_address,
   input  wire logic         pop_valid,
   output logic              pop_ready,
   input  wire dnsr_cmd_type pop_cmd,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_verdict,
   output logic              rsp_accept,
   output logic              rsp_end_of_run
);

   logic [4:0] step_ff, step_in;
   logic [4:0] cur_step;
   logic [3:0] ans_idx;
   logic       out_free;
   logic       emit;
   logic       done;
   logic [7:0] item_byte;
   logic       item_verdict;

   logic       rsp_valid_ff;
   logic [7:0] rsp_out_byte_ff;
   logic       rsp_is_verdict_ff;
   logic       rsp_accept_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = pop_valid && out_free;

   always_comb begin
      if (step_ff == STEP_BYTE && !pop_cmd.fwd) begin
         cur_step = pop_cmd.ok ? STEP_ANS_1ST : STEP_VERDICT;
      end else begin
         cur_step = step_ff;
      end
      ans_idx      = 4'(cur_step - STEP_ANS_1ST);
      item_verdict = 1'b0;
      item_byte    = 8'h00;
      done         = 1'b0;
      step_in      = step_ff;
      if (cur_step == STEP_BYTE) begin
         item_byte = pop_cmd.data;
         if (pop_cmd.last) begin
            step_in = pop_cmd.ok ? STEP_ANS_1ST : STEP_VERDICT;
         end else begin
            done = 1'b1;
         end
      end else if (cur_step == STEP_VERDICT) begin
         item_verdict = 1'b1;
         done         = 1'b1;
         step_in      = STEP_BYTE;
      end else begin
         item_byte = answer_byte(ans_idx, answer_address);
         step_in   = (cur_step == STEP_ANS_END) ? STEP_VERDICT : cur_step + 5'd1;
      end
   end

   assign pop_ready = out_free && done;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_BYTE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit) begin
            step_ff <= step_in;
         end
         if (out_free) begin
            rsp_valid_ff <= pop_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_out_byte_ff   <= item_byte;
         rsp_is_verdict_ff <= item_verdict;
         rsp_accept_ff     <= item_verdict && pop_cmd.ok;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_out_byte_ff;
   assign rsp_is_verdict = rsp_is_verdict_ff;
   assign rsp_accept     = rsp_accept_ff;
   assign rsp_end_of_run = rsp_is_verdict_ff;

endmodule

`default_nettype wire

@@ src/dns_a_query_hijack_responder.sv @@
// top level of the byte-serial dns a-record responder
//
//  channel  direction  beat contents
//  req_     in         data_byte, last_byte
//  rsp_     out        out_byte, is_verdict, accept, end_of_run
//  csr_     in         answer address (32 bit), one register
//
// one query byte a cycle is taken while the command queue has room
// a forwarded byte passes the queue, then the output register; the last byte of an
// accepted query is followed by the answer then the verdict, a rejected one by the verdict
// during the answer the four-entry queue fills and req_ready drops until the verdict is out
// synchronous reset clears the header walk, queue and output register; address resets to 0
// rsp_ready low stalls the output register, then the queue, then req_ready
`timescale 1ns / 1ps
`default_nettype none

module dns_a_query_hijack_responder import dnsr_pkg::*; #(
   parameter int BUF_BYTES = 512
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_is_verdict,
   output logic              rsp_accept,
   output logic              rsp_end_of_run,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [31:0]  csr_data
);

   logic [31:0]  answer_address_ff;
   logic         push_valid, push_ready;
   dnsr_cmd_type push_cmd;
   logic         pop_valid, pop_ready;
   dnsr_cmd_type pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         answer_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         answer_address_ff <= csr_data;
      end
   end

   dnsr_front #(
      .BUF_BYTES(BUF_BYTES)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd)
   );

   dnsr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_cmd(push_cmd),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd)
   );

   dnsr_back u_back (
      .clock(clock),
      .reset(reset),
      .answer_address(answer_address_ff),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_cmd(pop_cmd),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_verdict(rsp_is_verdict),
      .rsp_accept(rsp_accept),
      .rsp_end_of_run(rsp_end_of_run)
   );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// self-checking testbench of the dns a-record responder, directed queries then random traffic
`timescale 1ns / 1ps
`default_nettype none

module tb_top import dnsr_pkg::*; ();

   localparam int BUF_BYTES    = 512;
   localparam int SETTLE       = 2 * QUEUE_DEPTH + 6;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_BYTES = 160;
   localparam logic [95:0] ANSWER_HEAD = 96'hC00C_0001_0001_0000_001E_0004;

   typedef enum int {VERDICT_REJECT = 0, VERDICT_ACCEPT = 1, VERDICT_OPEN = 2} verdict_type;
   typedef enum int {HURT_QR, HURT_COUNT, HURT_POINTER, HURT_CUT, HURT_UNENDED} damage_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_verdict;
      logic       accept;
      logic       end_of_run;
   } reply_beat_type;

   typedef struct {
      bit          set_addr;
      logic [31:0] addr;
      logic [7:0]  flags;
      logic [15:0] qd;
      logic [7:0]  lab_len;
      int          n_lab;
      int          tail_len;
      bit          no_term;
      logic [15:0] qtype;
      int          pad;
      int          cut;
      logic [7:0]  fill;
      verdict_type verdict;
   } query_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_is_verdict;
   logic        rsp_accept;
   logic        rsp_end_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'h0;

   // reply predictor state
   int unsigned m_count, m_label_at, m_q_end;
   bit          m_name_done, m_bad;
   logic [7:0]  m_qd_hi;
   logic [15:0] m_qtype;
   logic [31:0] m_addr = 32'h0;

   reply_beat_type reply_q[$];
   logic [7:0]     query_bytes[$];
   query_row_type  plan[26];

   bit calm_tx = 1'b0, calm_rx = 1'b0;
   int rx_hold = 0;
   int idle_cycles = 0;
   int n_fail = 0, n_queries = 0, n_accepted = 0, n_rejected = 0;
   int n_bytes = 0, n_beats = 0, n_csr = 0, n_rand_bytes = 0;

   dns_a_query_hijack_responder #(.BUF_BYTES(BUF_BYTES)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_verdict(rsp_is_verdict),
      .rsp_accept(rsp_accept),
      .rsp_end_of_run(rsp_end_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pause_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic clear_packet_state();
      m_count     = 0;
      m_label_at  = HEADER_BYTES;
      m_name_done = 1'b0;
      m_q_end     = 0;
      m_qd_hi     = 8'h00;
      m_qtype     = 16'h0000;
      m_bad       = 1'b0;
   endtask

   // works out the reply beats caused by one accepted query byte
   task automatic predict_reply(input logic [7:0] b, input logic last, input verdict_type typed);
      int unsigned  pos;
      logic [7:0]   ob;
      bit           fwd, ok;
      logic [127:0] answer;
      int           i;
      if (m_count < BUF_BYTES) begin
         pos = m_count;
         ob  = b;
         fwd = !m_name_done || pos < m_q_end;
         case (pos)
            OFS_FLAGS_HI: begin
               if ((b & QR_BIT) != 8'h00) m_bad = 1'b1;
               ob = FLAGS_REPLY;
            end
            OFS_FLAGS_LO:  ob = 8'h00;
            OFS_QDCOUNT_H: m_qd_hi = b;
            OFS_QDCOUNT_L: if ({m_qd_hi, b} != ONE_QUESTION) m_bad = 1'b1;
            default: ;
         endcase
         if (pos >= OFS_COUNTS && pos < HEADER_BYTES) ob = (pos == OFS_ANCOUNT_L) ? 8'h01 : 8'h00;
         if (!m_name_done && pos == m_label_at) begin
            if (b == 8'h00) begin
               m_name_done = 1'b1;
               m_q_end     = pos + QTAIL_BYTES;
            end else if ((b & LABEL_PTR_MASK) == LABEL_PTR_MASK) begin
               m_bad      = 1'b1;
               m_label_at = BUF_BYTES + STOP_WALK_GAP;
            end else begin
               m_label_at = pos + b + 1;
            end
         end else if (m_name_done) begin
            if (pos + 4 == m_q_end) m_qtype[15:8] = b;
            else if (pos + 3 == m_q_end) m_qtype[7:0] = b;
         end
         if (fwd) reply_q.push_back(reply_beat_type'{ob, 1'b0, 1'b0, 1'b0});
         m_count = pos + 1;
      end
      if (last) begin
         ok = m_count >= HEADER_BYTES && !m_bad && m_name_done && m_q_end <= m_count &&
              m_qtype == QTYPE_A && m_q_end + ANSWER_BYTES <= BUF_BYTES;
         if (typed != VERDICT_OPEN) ok = (typed == VERDICT_ACCEPT);
         if (ok) begin
            answer = {ANSWER_HEAD, m_addr};
            for (i = 0; i < ANSWER_BYTES; i++)
               reply_q.push_back(reply_beat_type'{answer[127 - 8 * i -: 8], 1'b0, 1'b0, 1'b0});
            n_accepted++;
         end else begin
            n_rejected++;
         end
         reply_q.push_back(reply_beat_type'{8'h00, 1'b1, ok, 1'b1});
         clear_packet_state();
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last, input verdict_type typed);
      int gap;
      gap = (calm_tx || $urandom_range(0, 2) != 0) ? 0 : pause_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      predict_reply(b, last, typed);
      n_bytes++;
      @(negedge clock);
   endtask

   task automatic send_query(input verdict_type typed);
      int i;
      for (i = 0; i < query_bytes.size(); i++)
         send_byte(query_bytes[i], i == query_bytes.size() - 1, typed);
      n_queries++;
   endtask

   // sender holds off until every expected beat is out and the pipe is empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (reply_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_address(input logic [31:0] a);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= a;
      do @(posedge clock); while (!csr_ready);
      m_addr = a;
      n_csr++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic put_label(input logic [7:0] len, input logic [7:0] fill, input bit scramble);
      query_bytes.push_back(len);
      repeat (len) query_bytes.push_back(scramble ? 8'($urandom) : fill);
   endtask

   task automatic build_query(input query_row_type q);
      query_bytes = {};
      query_bytes.push_back(q.fill);
      query_bytes.push_back(q.fill);
      query_bytes.push_back(q.flags);
      query_bytes.push_back(q.fill);
      query_bytes.push_back(q.qd[15:8]);
      query_bytes.push_back(q.qd[7:0]);
      repeat (HEADER_BYTES - OFS_COUNTS) query_bytes.push_back(q.fill);
      repeat (q.n_lab) put_label(q.lab_len, q.fill, 1'b0);
      if (q.tail_len != 0) put_label(8'(q.tail_len), q.fill, 1'b0);
      if (!q.no_term) begin
         query_bytes.push_back(8'h00);
         query_bytes.push_back(q.qtype[15:8]);
         query_bytes.push_back(q.qtype[7:0]);
         query_bytes.push_back(q.fill);
         query_bytes.push_back(q.fill);
      end
      repeat (q.pad) query_bytes.push_back(q.fill);
      if (q.cut != 0)
         while (query_bytes.size() > q.cut) void'(query_bytes.pop_back());
   endtask

   // mostly well-formed a queries with random content, some damaged, some pure noise
   task automatic random_query();
      int          kind, len, term_at;
      logic [15:0] qtype;
      damage_type  hurt;
      query_bytes = {};
      kind = $urandom_range(0, 99);
      if (kind >= 88) begin
         repeat ($urandom_range(1, 30)) query_bytes.push_back(8'($urandom));
      end else begin
         query_bytes.push_back(8'($urandom));
         query_bytes.push_back(8'($urandom));
         query_bytes.push_back(8'($urandom) & ~QR_BIT);
         query_bytes.push_back(8'($urandom));
         query_bytes.push_back(ONE_QUESTION[15:8]);
         query_bytes.push_back(ONE_QUESTION[7:0]);
         repeat (HEADER_BYTES - OFS_COUNTS) query_bytes.push_back(8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 8'hBF) : $urandom_range(1, 8);
            put_label(8'(len), 8'h00, 1'b1);
         end
         qtype = ($urandom_range(0, 9) == 0) ? 16'($urandom) : QTYPE_A;
         term_at = query_bytes.size();
         query_bytes.push_back(8'h00);
         query_bytes.push_back(qtype[15:8]);
         query_bytes.push_back(qtype[7:0]);
         query_bytes.push_back(8'($urandom));
         query_bytes.push_back(8'($urandom));
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6)) query_bytes.push_back(8'($urandom));
         if (kind >= 70) begin
            hurt = damage_type'($urandom_range(0, 4));
            case (hurt)
               HURT_QR:      query_bytes[OFS_FLAGS_HI] = query_bytes[OFS_FLAGS_HI] | QR_BIT;
               HURT_COUNT: begin
                  query_bytes[OFS_QDCOUNT_H] = 8'($urandom_range(0, 1));
                  query_bytes[OFS_QDCOUNT_L] = 8'($urandom);
               end
               HURT_POINTER: query_bytes[HEADER_BYTES] = LABEL_PTR_MASK | 8'($urandom);
               HURT_CUT: begin
                  len = $urandom_range(1, query_bytes.size() - 1);
                  while (query_bytes.size() > len) void'(query_bytes.pop_back());
               end
               default:      query_bytes[term_at] = 8'($urandom_range(1, 63));
            endcase
         end
      end
   endtask

   // receiver stalls
   always @(negedge clock) begin
      if (rx_hold > 0) rx_hold--;
      else if (!calm_rx && $urandom_range(0, 2) == 0) rx_hold = pause_len();
      rsp_ready <= (rx_hold == 0);
   end

   // stretches with no idling on either side
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) calm_tx <= !calm_tx;
      if ($urandom_range(0, 199) == 0) calm_rx <= !calm_rx;
   end

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         n_fail++;
         $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      reply_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_q.size() == 0) begin
            n_fail++;
            $display("%0t: unexpected reply beat, expected none, got byte %02h verdict %0b",
                     $time, rsp_out_byte, rsp_is_verdict);
         end else begin
            want = reply_q.pop_front();
            check_field("out_byte", want.out_byte, rsp_out_byte);
            check_field("is_verdict", 8'(want.is_verdict), 8'(rsp_is_verdict));
            check_field("accept", 8'(want.accept), 8'(rsp_accept));
            check_field("end_of_run", 8'(want.end_of_run), 8'(rsp_end_of_run));
         end
         n_beats++;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("dns_a_query_hijack_responder verification failed");
         $finish;
      end
   end

   initial begin
      //       csr addr           flags  qdcount   label  n  tail unend qtype  pad cut  fill
      plan = '{
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'h00, VERDICT_ACCEPT},
         '{1, 32'hFFFFFFFF, 8'h7F, 16'h0001, 8'd63,  1, 0,  0, 16'h0001, 0,   0,  8'hFF, VERDICT_ACCEPT},
         '{0, 32'h0,        8'h80, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'hFF, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'hFF, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0000, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'h5A, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0002, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'hA5, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0101, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'hFFFF, 8'd3,   2, 0,  0, 16'h0001, 0,   0,  8'hFF, VERDICT_REJECT},
         '{1, 32'hC0A80001, 8'h00, 16'h0001, 8'd1,   0, 0,  0, 16'h0001, 0,   0,  8'h33, VERDICT_ACCEPT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h001C, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0100, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'hFFFF, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'hC0,  1, 0,  0, 16'h0001, 0,   0,  8'h11, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'hFF,  1, 0,  0, 16'h0001, 0,   0,  8'h22, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'h41,  1, 0,  0, 16'h0001, 0,   0,  8'h44, VERDICT_OPEN},
         '{0, 32'h0,        8'h01, 16'h0001, 8'h81,  1, 0,  0, 16'h0001, 0,   0,  8'h66, VERDICT_OPEN},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,   1,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,  11,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,  12,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 0,  24,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  0, 16'h0001, 7,   0,  8'h77, VERDICT_OPEN},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd3,   2, 0,  1, 16'h0001, 0,   0,  8'h00, VERDICT_REJECT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd63, 10, 0,  1, 16'h0001, 0,   0,  8'h00, VERDICT_REJECT},
         '{1, 32'h0,        8'h01, 16'h0001, 8'd1,   0, 0,  0, 16'h0001, 520, 0,  8'h99, VERDICT_ACCEPT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd63,  7, 30, 0, 16'h0001, 0,   0,  8'h00, VERDICT_ACCEPT},
         '{0, 32'h0,        8'h01, 16'h0001, 8'd63,  7, 39, 0, 16'h0001, 0,   0,  8'h00, VERDICT_REJECT}
      };
      clear_packet_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[r]) begin
         if (plan[r].set_addr) write_address(plan[r].addr);
         build_query(plan[r]);
         send_query(plan[r].verdict);
         if ($urandom_range(0, 3) == 0) wait_idle();
      end

      write_address($urandom);
      while (n_rand_bytes < RANDOM_BYTES) begin
         random_query();
         send_query(VERDICT_OPEN);
         n_rand_bytes += query_bytes.size();
         if (n_rand_bytes >= RANDOM_BYTES / 2 && n_csr < 5) write_address($urandom);
         else if ($urandom_range(0, 5) == 0) wait_idle();
      end
      wait_idle();
      n_fail += reply_q.size();

      $display("covered %0d queries (%0d answered, %0d refused), %0d query bytes, %0d reply beats",
               n_queries, n_accepted, n_rejected, n_bytes, n_beats);
      $display("answer address set %0d times, all-zero and all-one values included", n_csr);
      if (n_fail == 0)
         $display("dns_a_query_hijack_responder verification clean");
      else
         $display("dns_a_query_hijack_responder verification failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
src/dnsr_pkg.sv
src/dnsr_front.sv
src/dnsr_queue.sv
src/dnsr_back.sv
src/dns_a_query_hijack_responder.sv
sim/tb_top.sv
